[hw/rtl/cobs_enc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS encoder package
// Shared constants and word types for the COBS frame encoder.
// ----------------------------------------------------------------------------
package cobs_enc_pkg;

  // Longest run of nonzero bytes kept before further bytes are dropped.
  localparam int MAX_RUN      = 62;
  // Most bytes one input word may cause.
  localparam int RESULT_LIMIT = 64;
  localparam int LEN_W        = $clog2(MAX_RUN + 1);
  localparam int IDX_W        = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       frame_end;
    logic       overflow;
  } out_word_t;

  // One flush job handed from the front to the back.
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             empty_run;  // append a code byte for an empty run
    logic             delim;      // append the frame delimiter
    logic             ovf;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } job_done_t;

endpackage

[hw/rtl/cobs_enc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS encoder front
// Accepts message bytes, fills the run store and issues flush jobs.
// ----------------------------------------------------------------------------
module cobs_enc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  cobs_enc_pkg::in_word_t in_word_i,
  output cobs_enc_pkg::store_wr_t store_wr_o,
  output logic                  cmd_push_o,
  output cobs_enc_pkg::cmd_t    cmd_o,
  input  cobs_enc_pkg::job_done_t job_done_i
);
  import cobs_enc_pkg::*;

  logic [LEN_W-1:0] len_q, len_d;
  logic             bank_q, bank_d;
  logic             ovf_q, ovf_d;
  logic [1:0]       busy_q, busy_d;

  logic accept, is_zero, last, room, drop_zero, store_en, ovf_now;

  // A bank stays busy from its flush job until the back has sent every byte.
  assign full      = busy_q[bank_q];
  assign accept    = push && !full;
  assign is_zero   = (in_word_i.data_byte == 8'h00);
  assign last      = in_word_i.end_of_message;
  assign room      = (int'(len_q) < MAX_RUN);
  assign drop_zero = is_zero && last && ((int'(len_q) + 3) > RESULT_LIMIT);
  assign store_en  = accept && !is_zero && room;
  assign ovf_now   = ovf_q || (accept && ((!is_zero && !room) || drop_zero));

  assign store_wr_o.en   = store_en;
  assign store_wr_o.bank = bank_q;
  assign store_wr_o.idx  = len_q[IDX_W-1:0];
  assign store_wr_o.data = in_word_i.data_byte;

  assign cmd_push_o      = accept && (is_zero || last);
  assign cmd_o.bank      = bank_q;
  assign cmd_o.len       = (!is_zero && room) ? len_q + LEN_W'(1) : len_q;
  assign cmd_o.empty_run = is_zero && last && !drop_zero;
  assign cmd_o.delim     = last;
  assign cmd_o.ovf       = ovf_now;

  always_comb begin
    len_d  = len_q;
    bank_d = bank_q;
    ovf_d  = ovf_now;
    busy_d = busy_q;
    if (job_done_i.valid) begin
      busy_d[job_done_i.bank] = 1'b0;
    end
    if (cmd_push_o) begin
      len_d          = '0;
      bank_d         = !bank_q;
      busy_d[bank_q] = 1'b1;
      if (last) begin
        ovf_d = 1'b0;
      end
    end else if (store_en) begin
      len_d = len_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      bank_q <= 1'b0;
      ovf_q  <= 1'b0;
      busy_q <= '0;
    end else begin
      len_q  <= len_d;
      bank_q <= bank_d;
      ovf_q  <= ovf_d;
      busy_q <= busy_d;
    end
  end

endmodule

[hw/rtl/cobs_enc_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS encoder job queue
// Two-entry queue of flush jobs between the front and the back.
// ----------------------------------------------------------------------------
module cobs_enc_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cobs_enc_pkg::cmd_t cmd_i,
  input  logic               pop_i,
  output logic               empty_o,
  output cobs_enc_pkg::cmd_t cmd_o
);
  import cobs_enc_pkg::*;

  // The two bank busy bits in the front keep at most two jobs in flight,
  // so the queue never overfills.
  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

[hw/rtl/cobs_enc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS encoder back
// Holds the run store and plays out each flush job as frame bytes.
// ----------------------------------------------------------------------------
module cobs_enc_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cobs_enc_pkg::store_wr_t store_wr_i,
  input  logic                    cmd_empty_i,
  input  cobs_enc_pkg::cmd_t      cmd_i,
  output logic                    cmd_pop_o,
  output cobs_enc_pkg::job_done_t job_done_o,
  output logic                    empty,
  input  logic                    pop,
  output cobs_enc_pkg::out_word_t out_word_o
);
  import cobs_enc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CODE  = 5'b00010,
    S_DATA  = 5'b00100,
    S_EMPTY = 5'b01000,
    S_DELIM = 5'b10000
  } state_e;

  logic [7:0]       store_mem [2][MAX_RUN];
  logic [7:0]       rd_q;
  state_e           state_q, state_d;
  cmd_t             job_q;
  logic [LEN_W-1:0] idx_q, idx_d, rd_idx;
  logic             rd_en;
  logic             out_valid_q;
  out_word_t        out_q, out_d;
  logic             load, out_free, done;
  state_e           after_run;

  assign out_free   = !out_valid_q || pop;
  assign empty      = !out_valid_q;
  assign out_word_o = out_q;
  assign job_done_o.valid = done;
  assign job_done_o.bank  = job_q.bank;

  always_comb begin
    if (job_q.empty_run) begin
      after_run = S_EMPTY;
    end else if (job_q.delim) begin
      after_run = S_DELIM;
    end else begin
      after_run = S_IDLE;
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    rd_en     = 1'b0;
    rd_idx    = '0;
    load      = 1'b0;
    done      = 1'b0;
    cmd_pop_o = 1'b0;
    out_d     = out_q;
    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          state_d   = S_CODE;
        end
      end
      S_CODE: begin
        if (out_free) begin
          load  = 1'b1;
          out_d = '{coded_byte: 8'(job_q.len) + 8'd1, frame_end: 1'b0,
                    overflow: job_q.ovf};
          idx_d = '0;
          if (job_q.len != '0) begin
            rd_en   = 1'b1;
            state_d = S_DATA;
          end else begin
            state_d = after_run;
            done    = (after_run == S_IDLE);
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          load   = 1'b1;
          out_d  = '{coded_byte: rd_q, frame_end: 1'b0, overflow: job_q.ovf};
          idx_d  = idx_q + LEN_W'(1);
          rd_idx = idx_d;
          if (idx_d < job_q.len) begin
            rd_en = 1'b1;
          end else begin
            state_d = after_run;
            done    = (after_run == S_IDLE);
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          load  = 1'b1;
          out_d = '{coded_byte: 8'd1, frame_end: 1'b0, overflow: job_q.ovf};
          if (job_q.delim) begin
            state_d = S_DELIM;
          end else begin
            state_d = S_IDLE;
            done    = 1'b1;
          end
        end
      end
      S_DELIM: begin
        if (out_free) begin
          load    = 1'b1;
          out_d   = '{coded_byte: 8'h00, frame_end: 1'b1, overflow: job_q.ovf};
          state_d = S_IDLE;
          done    = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Run store: the front writes one bank while the back reads the other.
  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      store_mem[store_wr_i.bank][store_wr_i.idx] <= store_wr_i.data;
    end
    if (rd_en) begin
      rd_q <= store_mem[job_q.bank][rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      job_q <= cmd_i;
    end
    if (load) begin
      out_q <= out_d;
    end
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/cobs_frame_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame encoder
// Nonzero bytes are accepted one per cycle while the current bank is free;
// a flush fetches its job, then plays out code, run bytes, empty-run code and
// delimiter at one byte per cycle while the receiver keeps popping.
// Two run store banks let the front run up to two flushes ahead of the back.
// Reset clears the state, pointers and flags; the run store is not cleared.
// ----------------------------------------------------------------------------
module cobs_frame_encoder (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  cobs_enc_pkg::in_word_t  in_word_i,
  output logic                    empty,
  input  logic                    pop,
  output cobs_enc_pkg::out_word_t out_word_o
);
  import cobs_enc_pkg::*;

  store_wr_t store_wr;
  cmd_t      cmd_in, cmd_out;
  logic      cmd_push, cmd_pop, cmd_empty;
  job_done_t job_done;

  cobs_enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .store_wr_o (store_wr),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .job_done_i (job_done)
  );

  cobs_enc_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_out)
  );

  cobs_enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .store_wr_i  (store_wr),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .job_done_o  (job_done),
    .empty       (empty),
    .pop         (pop),
    .out_word_o  (out_word_o)
  );

endmodule

[verif/cobs_frame_checker_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame checker
// Predicts the encoded frame bytes for every accepted message byte and checks
// each popped word against the oldest predicted one.
// ----------------------------------------------------------------------------
package cobs_frame_checker_pkg;

  import cobs_enc_pkg::*;

  class cobs_frame_checker;

    logic [7:0]  run_bytes [MAX_RUN];
    int unsigned run_len;
    bit          ovf_seen;
    out_word_t   coded_due [$];
    int          errors;

    function new();
      run_len  = 0;
      ovf_seen = 1'b0;
      errors   = 0;
    endfunction

    function int pending();
      return coded_due.size();
    endfunction

    function void emit(logic [7:0] b, bit fe);
      out_word_t w;
      w.coded_byte = b;
      w.frame_end  = fe;
      w.overflow   = ovf_seen;
      coded_due.push_back(w);
    endfunction

    // Code byte first, then the stored run.
    function void flush_run();
      emit(8'(run_len + 1), 1'b0);
      for (int i = 0; i < run_len; i++) emit(run_bytes[i], 1'b0);
      run_len = 0;
    endfunction

    function void note_byte(in_word_t w);
      if (w.data_byte == 8'h00) begin
        // A final zero after a full run would overrun the result limit, so it
        // is dropped and the frame closes without the empty-run code.
        if (w.end_of_message && run_len + 3 > RESULT_LIMIT) begin
          ovf_seen = 1'b1;
        end else begin
          flush_run();
        end
      end else if (run_len < MAX_RUN) begin
        run_bytes[run_len] = w.data_byte;
        run_len++;
      end else begin
        ovf_seen = 1'b1;
      end
      if (w.end_of_message) begin
        flush_run();
        emit(8'h00, 1'b1);
        run_len  = 0;
        ovf_seen = 1'b0;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_coded(out_word_t got);
      out_word_t want;
      if (coded_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h", got));
        return;
      end
      want = coded_due.pop_front();
      if (got.coded_byte !== want.coded_byte)
        flag_mismatch($sformatf("coded_byte %h, want %h", got.coded_byte, want.coded_byte));
      if (got.frame_end !== want.frame_end)
        flag_mismatch($sformatf("frame_end %b, want %b", got.frame_end, want.frame_end));
      if (got.overflow !== want.overflow)
        flag_mismatch($sformatf("overflow %b, want %b", got.overflow, want.overflow));
    endtask

  endclass

endpackage

[verif/tb_cobs_frame_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame encoder testbench
// Drives short directed messages, long runs that hit the run store limit and
// random messages under several idle and stall mixes, including one long
// receiver hold-off, and checks every popped word against a predictor.
// ----------------------------------------------------------------------------
module tb_cobs_frame_encoder;

  import cobs_enc_pkg::*;
  import cobs_frame_checker_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 5;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_word_t  in_word_i;
  logic      empty;
  logic      pop;
  out_word_t out_word_o;

  cobs_frame_checker chk;
  int  idle_pct;
  int  stall_pct;
  int  items_sent;
  bit  hold_off_req;

  cobs_frame_encoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word_i),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    rst_ni     = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    in_word_i  = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    items_sent = 0;
    hold_off_req = 1'b0;
    chk = new();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Both handshakes are seen with the values they had at the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) chk.note_byte(in_word_i);
      if (pop && !empty) chk.check_coded(out_word_o);
    end
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  always begin
    @(negedge clk_i);
    if (rst_ni) begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic [7:0] b, bit eom);
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    push <= 1'b1;
    in_word_i <= '{data_byte: b, end_of_message: eom};
    forever begin
      @(posedge clk_i);
      if (!full) break;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_byte(int zero_pct);
    if ($urandom_range(99) < zero_pct) return 8'h00;
    return 8'($urandom_range(255, 1));
  endfunction

  task automatic send_short(int len, int zero_pct);
    for (int i = 0; i < len; i++) send_word(rand_byte(zero_pct), i == len - 1);
  endtask

  // A run of nonzero bytes, some further random bytes, then the final byte.
  task automatic send_long(int run, int extra, bit zero_end);
    for (int i = 0; i < run; i++) send_word(rand_byte(0), 1'b0);
    for (int i = 0; i < extra; i++) send_word(rand_byte(30), 1'b0);
    send_word(zero_end ? 8'h00 : rand_byte(0), 1'b1);
  endtask

  task automatic send_random_message();
    send_short($urandom_range(12, 1), 25);
  endtask

  task automatic run_phase(int idle, int stall, int n_items);
    int start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = items_sent;
    while (items_sent - start < n_items) send_random_message();
  endtask

  initial begin
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    // Single-byte messages at the field extremes.
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h01, 1'b1);
    // Zeros inside a message, back to back and at the end.
    send_word(8'h11, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h22, 1'b0);
    send_word(8'h33, 1'b1);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hAA, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'h00, 1'b1);

    // Longest frame, then a run past the store limit that also drops its
    // final zero.
    send_long(61, 0, 1'b1);
    send_long(63, 0, 1'b1);

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(82, 0, PHASE_ITEMS);
    run_phase(0, 82, PHASE_ITEMS);
    run_phase(12, 12, PHASE_ITEMS);

    // Receiver stops for a long stretch while the sender keeps pushing.
    // Three one-byte frames need three flushes, which fills both banks.
    hold_off_req = 1'b1;
    send_word(8'h5A, 1'b1);
    send_word(8'hA5, 1'b1);
    send_word(8'h3C, 1'b1);
    run_phase(0, 0, PHASE_ITEMS);
    push <= 1'b0;

    while (chk.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (chk.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
